// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

  localparam int BUF_BYTES = 64;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int WPOS_W    = $clog2(BUF_BYTES + 1);
  localparam int RAM_DEPTH = 2 * BUF_BYTES;
  localparam int RAM_AW    = BUF_AW + 1;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [7:0] MARKER     = 8'hAA;
  localparam logic [7:0] KEY_OFFSET = 8'd136;

  typedef enum logic [1:0] {
    KIND_PRESENCE = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_EMPTY    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SRC  = 3'd1,
    PH_DST  = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } rx_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_EMIT  = 2'd2,
    BK_EMPTY = 2'd3
  } back_state_t;

  // One unit of work for the back end: a presence byte or a checked packet
  typedef struct packed {
    logic       is_pkt;
    logic       bank;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] byte_val;  // presence byte, or the seed of a packet
    logic [5:0] plen;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// ===== rtl/sfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sfr_job_fifo.sv =====
// Short job queue between the receive front end and the result back end.
module sfr_job_fifo import sfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic valid
);

  job_t              q_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt;
  logic [Q_AW-1:0]   rp_r, rp_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !valid |-> !pop)
    else $error("job popped from an empty queue");
`endif

endmodule

// ===== rtl/sfr_front.sv =====
// Receive front end: unstuffing, frame parsing, checksum and buffer writes.
module sfr_front import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [7:0] in_tdata,
  output logic      job_push,
  output job_t      job,
  input  logic      q_full,
  output ram_wr_t   ram_wr,
  input  bank_rel_t rel
);

  rx_phase_t         phase_r, phase_nxt;
  logic              esc_r, esc_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        src_r, src_nxt;
  logic [7:0]        dst_r, dst_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [WPOS_W-1:0] wpos_r, wpos_nxt;
  logic [7:0]        seed_r, seed_nxt;
  logic [7:0]        csum_lo_r, csum_lo_nxt;
  logic              wb_r, wb_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic              accept;
  logic [7:0]        m;
  logic              mark;
  logic              esc_hit;
  rx_phase_t         eff_phase;
  logic [15:0]       sum_base;
  logic [8:0]        pos9;
  logic [8:0]        len9;
  logic              overrun;
  logic              frame_end;
  logic              csum_ok;

  assign in_tready = !q_full && !busy_r[wb_r];
  assign accept    = in_tvalid && in_tready;
  assign m         = in_tdata;
  assign mark      = !esc_r && (m == MARKER);
  assign esc_hit   = esc_r && (m != MARKER);
  // An escaped non-marker byte restarts the frame and is its source byte
  assign eff_phase = esc_hit ? PH_SRC : phase_r;
  assign sum_base  = esc_hit ? 16'd0 : sum_r;
  assign pos9      = 9'(wpos_r);
  assign len9      = {1'b0, len_r};
  assign overrun   = (wpos_r >= WPOS_W'(BUF_BYTES));
  assign frame_end = !overrun && (pos9 == len9 + 9'd1);
  assign csum_ok   = ({m, csum_lo_r} == sum_base);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept && !mark) begin
      unique case (eff_phase)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_SRC:  phase_nxt = PH_DST;
        PH_DST:  phase_nxt = PH_LEN;
        PH_LEN:  phase_nxt = (m != 8'd0) ? PH_BODY : PH_IDLE;
        PH_BODY: phase_nxt = (overrun || frame_end) ? PH_IDLE : PH_BODY;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Datapath and outputs
  always_comb begin
    esc_nxt     = esc_r;
    sum_nxt     = sum_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    len_nxt     = len_r;
    wpos_nxt    = wpos_r;
    seed_nxt    = seed_r;
    csum_lo_nxt = csum_lo_r;
    wb_nxt      = wb_r;
    busy_nxt    = busy_r;
    job_push    = 1'b0;
    job         = '0;
    ram_wr      = '0;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      esc_nxt = mark;
      if (!mark) begin
        unique case (eff_phase)
          PH_IDLE: begin
            job_push     = 1'b1;
            job.is_pkt   = 1'b0;
            job.byte_val = m;
          end
          PH_SRC: begin
            src_nxt = m;
            sum_nxt = sum_base + 16'(m);
          end
          PH_DST: begin
            dst_nxt = m;
            sum_nxt = sum_base + 16'(m);
          end
          PH_LEN: begin
            if (m != 8'd0) begin
              wpos_nxt = '0;
              len_nxt  = m;
              sum_nxt  = sum_base + 16'(m);
            end
          end
          PH_BODY: begin
            // Drop the frame silently once the buffer is full
            if (!overrun) begin
              ram_wr.en   = 1'b1;
              ram_wr.addr = {wb_r, wpos_r[BUF_AW-1:0]};
              ram_wr.data = m;
              wpos_nxt    = wpos_r + 1'b1;
              if (pos9 < len9) begin
                sum_nxt = sum_r + 16'(m);
              end
              if (wpos_r == '0) begin
                seed_nxt = m;
              end
              if (pos9 == len9) begin
                csum_lo_nxt = m;
              end
              if (frame_end && csum_ok) begin
                job_push         = 1'b1;
                job.is_pkt       = 1'b1;
                job.bank         = wb_r;
                job.src          = src_r;
                job.dst          = dst_r;
                job.byte_val     = seed_r;
                job.plen         = 6'(len_r - 8'd1);
                busy_nxt[wb_r]   = 1'b1;
                wb_nxt           = !wb_r;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      esc_r     <= 1'b0;
      sum_r     <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      len_r     <= '0;
      wpos_r    <= '0;
      seed_r    <= '0;
      csum_lo_r <= '0;
      wb_r      <= 1'b0;
      busy_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      esc_r     <= esc_nxt;
      sum_r     <= sum_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      len_r     <= len_nxt;
      wpos_r    <= wpos_nxt;
      seed_r    <= seed_nxt;
      csum_lo_r <= csum_lo_nxt;
      wb_r      <= wb_nxt;
      busy_r    <= busy_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |-> !busy_r[ram_wr.addr[RAM_AW-1]])
    else $error("frame write into a bank still being emitted");
`endif

endmodule

// ===== rtl/sfr_back.sv =====
// Result back end: runs queued jobs, descrambles payload, holds the output beat.
module sfr_back import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output bank_rel_t         rel,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // src_addr, dst_addr, data_byte, byte_index, pad
  output logic [1:0]        out_tuser,   // kind
  output logic              out_tlast
);

  back_state_t state_r, state_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  dst_r, dst_nxt;
  logic [7:0]  seed_r, seed_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        bank_r, bank_nxt;

  logic        ovld_r, ovld_nxt;
  kind_t       okind_r, okind_nxt;
  logic [7:0]  osrc_r, osrc_nxt;
  logic [7:0]  odst_r, odst_nxt;
  logic [7:0]  odata_r, odata_nxt;
  logic [5:0]  oidx_r, oidx_nxt;
  logic        olast_r, olast_nxt;

  logic        slot_free;
  logic        pay_last;

  assign slot_free = !ovld_r || out_tready;
  assign pay_last  = (idx_r + 6'd1 == plen_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid && job.is_pkt) begin
          state_nxt = (job.plen == 6'd0) ? BK_EMPTY : BK_READ;
        end
      end
      BK_READ:  state_nxt = BK_EMIT;
      BK_EMIT:  state_nxt = (slot_free && pay_last) ? BK_IDLE
                          : (slot_free ? BK_READ : BK_EMIT);
      BK_EMPTY: state_nxt = slot_free ? BK_IDLE : BK_EMPTY;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    seed_nxt  = seed_r;
    key_nxt   = key_r;
    plen_nxt  = plen_r;
    idx_nxt   = idx_r;
    bank_nxt  = bank_r;
    ovld_nxt  = ovld_r && !out_tready;
    okind_nxt = okind_r;
    osrc_nxt  = osrc_r;
    odst_nxt  = odst_r;
    odata_nxt = odata_r;
    oidx_nxt  = oidx_r;
    olast_nxt = olast_r;
    job_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {bank_r, BUF_AW'(7'(idx_r) + 7'd1)};
    rel       = '0;

    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          if (!job.is_pkt) begin
            if (slot_free) begin
              job_pop   = 1'b1;
              ovld_nxt  = 1'b1;
              okind_nxt = KIND_PRESENCE;
              osrc_nxt  = 8'd0;
              odst_nxt  = 8'd0;
              odata_nxt = job.byte_val;
              oidx_nxt  = 6'd0;
              olast_nxt = 1'b1;
            end
          end else begin
            job_pop  = 1'b1;
            src_nxt  = job.src;
            dst_nxt  = job.dst;
            seed_nxt = job.byte_val;
            key_nxt  = job.byte_val + KEY_OFFSET;
            plen_nxt = job.plen;
            idx_nxt  = 6'd0;
            bank_nxt = job.bank;
          end
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
      end
      BK_EMIT: begin
        // Read data holds until the output slot frees up
        if (slot_free) begin
          ovld_nxt  = 1'b1;
          okind_nxt = KIND_PAYLOAD;
          osrc_nxt  = src_r;
          odst_nxt  = dst_r;
          odata_nxt = rd_data ^ key_r;
          oidx_nxt  = idx_r;
          olast_nxt = pay_last;
          key_nxt   = (key_r + seed_r) ^ seed_r;
          idx_nxt   = idx_r + 6'd1;
          if (pay_last) begin
            rel.valid = 1'b1;
            rel.bank  = bank_r;
          end
        end
      end
      BK_EMPTY: begin
        if (slot_free) begin
          ovld_nxt  = 1'b1;
          okind_nxt = KIND_EMPTY;
          osrc_nxt  = src_r;
          odst_nxt  = dst_r;
          odata_nxt = 8'd0;
          oidx_nxt  = 6'd0;
          olast_nxt = 1'b1;
          rel.valid = 1'b1;
          rel.bank  = bank_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    seed_r  <= seed_nxt;
    key_r   <= key_nxt;
    plen_r  <= plen_nxt;
    idx_r   <= idx_nxt;
    bank_r  <= bank_nxt;
    okind_r <= okind_nxt;
    osrc_r  <= osrc_nxt;
    odst_r  <= odst_nxt;
    odata_r <= odata_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {2'b00, oidx_r, odata_r, odst_r, osrc_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT || state_r == BK_READ) |-> (idx_r < plen_r))
    else $error("payload index ran past packet length");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |=> (state_r == BK_EMIT))
    else $error("buffer read not followed by emit");
`endif

endmodule

// ===== rtl/stuffed_frame_receiver_top.sv =====
// Top level of the byte-stuffed serial frame receiver.
// Accepts one received byte per beat, at most one per cycle. The front end
// unstuffs, parses and checksums frames on the fly, writing frame bytes into
// one of two 64-byte buffer banks; each presence byte and each checked
// packet becomes a job in a two-entry queue. The back end turns a presence
// job into one result and a packet into one result per payload byte
// (buffer read, then descramble into the output register), or a single
// empty-packet result. Input stalls while the job queue is full or while
// the bank the next frame would use still holds a packet not yet emitted.
// The buffers need no clearing after reset.
module stuffed_frame_receiver_top import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // src_addr, dst_addr, data_byte, byte_index, pad
  output logic [1:0]  out_tuser,   // kind
  output logic        out_tlast
);

  logic              job_push;
  job_t              job_in;
  logic              q_full;
  logic              job_pop;
  job_t              job_out;
  logic              job_valid;
  ram_wr_t           ram_wr;
  bank_rel_t         rel;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_push  (job_push),
    .job       (job_in),
    .q_full    (q_full),
    .ram_wr    (ram_wr),
    .rel       (rel)
  );

  sfr_job_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (q_full),
    .pop   (job_pop),
    .dout  (job_out),
    .valid (job_valid)
  );

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job_out),
    .job_pop    (job_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
